// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/swer_pkg.sv -----
// types and constants of the sliding window event rate block
// no dependencies; used by the interfaces and all modules
`timescale 1ns / 1ps

package swer_pkg;

    localparam int TIME_W     = 64;
    localparam int CNT_W      = 32;
    localparam int WIN_W      = 32;
    localparam int SCALE_W    = 48;
    localparam int SCALE_LO_W = 24;
    localparam int PART_W     = CNT_W + SCALE_LO_W;
    localparam int PROD_W     = CNT_W + SCALE_W;
    localparam int RATE_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE    = 2'd3;

    // configuration reset values
    localparam logic [TIME_W-1:0]  START_RESET  = '0;
    localparam logic [TIME_W-1:0]  STOP_RESET   = '1;
    localparam logic [WIN_W-1:0]   WIN_RESET    = 32'd1000000;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 48'd65536;

    localparam logic [CNT_W-1:0]   CNT_MAX      = '1;

    // per-cell command from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
        logic bump;
    } cell_ctrl_t;

    // one result on its way into the rate unit
    typedef struct packed {
        logic [TIME_W-1:0] rel_time;
        logic [CNT_W-1:0]  count;
        logic              overflow;
        logic              last;
    } rate_req_t;

endpackage

// ----- rtl/swer_if.sv -----
// valid/ready channel interfaces: events in, rate results out, config writes
// depends on swer_pkg
`timescale 1ns / 1ps

interface swer_event_if import swer_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] event_time;

    modport source (output valid, output event_time, input ready);
    modport sink   (input valid, input event_time, output ready);
endinterface

interface swer_rate_if import swer_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] rate_time;
    logic [CNT_W-1:0]  event_count;
    logic [RATE_W-1:0] rate_value;
    logic              last_of_run;
    logic              overflow_seen;

    modport source (output valid, output rate_time, output event_count,
                    output rate_value, output last_of_run, output overflow_seen,
                    input ready);
    modport sink   (input valid, input rate_time, input event_count,
                    input rate_value, input last_of_run, input overflow_seen,
                    output ready);
endinterface

interface swer_cfg_if import swer_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/swer_cell.sv -----
// one slot of the distinct-timestamp chain: time and multiplicity
// depends on swer_pkg; instantiated in a row by the top level
`timescale 1ns / 1ps

module swer_cell import swer_pkg::*; (
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [TIME_W-1:0] up_time,
    input  logic [CNT_W-1:0]  up_mult,
    input  logic [TIME_W-1:0] load_time,
    output logic [TIME_W-1:0] slot_time,
    output logic [CNT_W-1:0]  slot_mult
);

    logic [TIME_W-1:0] time_reg;
    logic [CNT_W-1:0]  mult_reg;

    // pop moves the neighbor down, push writes the new tail, bump counts a repeat
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            time_reg <= up_time;
            mult_reg <= up_mult;
        end
        else if (ctrl.load)
        begin
            time_reg <= load_time;
            mult_reg <= CNT_W'(1);
        end
        else if (ctrl.bump && (mult_reg != CNT_MAX))
        begin
            mult_reg <= mult_reg + CNT_W'(1);
        end
    end

    assign slot_time = time_reg;
    assign slot_mult = mult_reg;

endmodule

// ----- rtl/swer_rate.sv -----
// rate unit: count times scale in two partial products, then output register
// depends on swer_pkg and swer_rate_if; instantiated by the top level
`timescale 1ns / 1ps

module swer_rate import swer_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  rate_req_t          req,
    output logic               req_ready,
    input  logic [TIME_W-1:0]  origin,
    input  logic [SCALE_W-1:0] scale,
    swer_rate_if.source        rates
);

    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic [PART_W-1:0] s1_plo_reg;
    logic [PART_W-1:0] s1_phi_reg;
    logic [CNT_W-1:0]  s1_cnt_reg;
    logic              s1_ovf_reg;
    logic              s1_last_reg;

    logic              out_valid_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    logic              s1_adv;
    logic [PART_W-1:0] plo_next;
    logic [PART_W-1:0] phi_next;
    logic [PROD_W-1:0] prod;
    logic [RATE_W-1:0] rate_next;

    // handshake between the stages
    assign s1_adv    = !out_valid_reg || rates.ready;
    assign req_ready = !s1_valid_reg || s1_adv;

    // partial products on the low and high halves of the scale
    assign plo_next = PART_W'(req.count) * PART_W'(scale[SCALE_LO_W-1:0]);
    assign phi_next = PART_W'(req.count) * PART_W'(scale[SCALE_W-1:SCALE_LO_W]);

    // recombine and saturate at all ones
    assign prod      = {s1_phi_reg, {SCALE_LO_W{1'b0}}} + PROD_W'(s1_plo_reg);
    assign rate_next = (prod[PROD_W-1:RATE_W] != '0) ? '1 : prod[RATE_W-1:0];

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_time_reg <= req.rel_time + origin;
            s1_plo_reg  <= plo_next;
            s1_phi_reg  <= phi_next;
            s1_cnt_reg  <= req.count;
            s1_ovf_reg  <= req.overflow;
            s1_last_reg <= req.last;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_time_reg <= s1_time_reg;
            out_cnt_reg  <= s1_cnt_reg;
            out_rate_reg <= rate_next;
            out_last_reg <= s1_last_reg;
            out_ovf_reg  <= s1_ovf_reg;
        end
    end

    assign rates.valid         = out_valid_reg;
    assign rates.rate_time     = out_time_reg;
    assign rates.event_count   = out_cnt_reg;
    assign rates.rate_value    = out_rate_reg;
    assign rates.last_of_run   = out_last_reg;
    assign rates.overflow_seen = out_ovf_reg;

endmodule

// ----- rtl/sliding_window_event_rate.sv -----
// A result the sequencer issues passes the rate unit's s1 and output registers before it leaves.
// Each event passes IDLE, CHECK, TIME, then SAMPLE and EXPIRE if it moves time forward
// on a non-empty store, and PUSH; an ignored event goes from CHECK back to IDLE.
// No new event is taken until IDLE; EXPIRE pops one slot per cycle unless results stall.
// Reset: control and config go to their defaults; the slot chain is not cleared.
// depends on swer_pkg, swer_if, swer_cell, swer_rate, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_event_rate import swer_pkg::*; #(
    parameter int DISTINCT_DEPTH = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    swer_cfg_if.sink    cfg,
    swer_event_if.sink  events,
    swer_rate_if.source rates
);

    localparam int USED_W = $clog2(DISTINCT_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TIME,
        S_SAMPLE,
        S_EXPIRE,
        S_PUSH
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  stop_reg;
    logic [WIN_W-1:0]   wl_reg;
    logic [SCALE_W-1:0] scale_reg;

    // control state
    logic              have_origin_reg, have_origin_next;
    logic [TIME_W-1:0] origin_reg, origin_next;
    logic [TIME_W-1:0] prior_reg, prior_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              halted_reg, halted_next;
    logic              overflow_reg, overflow_next;

    // payload
    logic [TIME_W-1:0] ev_reg;
    logic [TIME_W-1:0] diff_reg, diff_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [TIME_W-1:0] back_time_reg, back_time_next;

    // chain
    cell_ctrl_t        cell_ctrl [DISTINCT_DEPTH];
    logic [TIME_W-1:0] cell_time [DISTINCT_DEPTH];
    logic [CNT_W-1:0]  cell_mult [DISTINCT_DEPTH];
    logic              pop;
    logic              push_new;
    logic              push_bump;

    // rate unit request
    logic      req_valid;
    logic      req_ready;
    rate_req_t req;

    // datapath terms
    logic [TIME_W-1:0] front;
    logic [TIME_W-1:0] second;
    logic [TIME_W-1:0] wl64;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] head_age;
    logic [TIME_W-1:0] next_age;
    logic              sample_ok;
    logic              head_exp;
    logic              next_exp;
    logic [TIME_W-1:0] origin_sel;
    logic [CNT_W-1:0]  total_inc;
    logic [CNT_W-1:0]  total_dec;

    assign front  = cell_time[0];
    assign second = cell_time[1];
    assign wl64   = TIME_W'(wl_reg);

    // one-tick sample fits when back + 1 is still inside the oldest window
    assign gap       = back_time_reg - front;
    assign sample_ok = (wl_reg != '0) && (gap < (wl64 - TIME_W'(1)));

    // expiry of the oldest and second oldest entries
    assign head_age = t_reg - front;
    assign next_age = t_reg - second;
    assign head_exp = (t_reg >= front) && (head_age >= wl64);
    assign next_exp = (used_reg >= USED_W'(2)) && (t_reg >= second) && (next_age >= wl64);

    assign origin_sel = have_origin_reg ? origin_reg : ev_reg;
    assign total_inc  = (total_reg != CNT_MAX) ? total_reg + CNT_W'(1) : total_reg;
    assign total_dec  = (total_reg > cell_mult[0]) ? total_reg - cell_mult[0] : '0;

    assign events.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    // sequencer next-state logic
    always_comb
    begin
        state_next       = state_reg;
        have_origin_next = have_origin_reg;
        origin_next      = origin_reg;
        prior_next       = prior_reg;
        used_next        = used_reg;
        total_next       = total_reg;
        halted_next      = halted_reg;
        overflow_next    = overflow_reg;
        diff_next        = diff_reg;
        t_next           = t_reg;
        back_time_next   = back_time_reg;
        pop              = 1'b0;
        push_new         = 1'b0;
        push_bump        = 1'b0;
        req_valid        = 1'b0;
        req.rel_time     = back_time_reg + TIME_W'(1);
        req.count        = total_reg;
        req.overflow     = overflow_reg;
        req.last         = !head_exp;

        case (state_reg)
            S_IDLE:
            begin
                if (events.valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (!halted_reg && (ev_reg >= start_reg))
                begin
                    if (ev_reg >= stop_reg)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        have_origin_next = 1'b1;
                        origin_next      = origin_sel;
                        diff_next        = (ev_reg >= origin_sel) ? ev_reg - origin_sel : '0;
                        state_next       = S_TIME;
                    end
                end
            end
            S_TIME:
            begin
                t_next = (diff_reg > prior_reg) ? diff_reg : prior_reg;
                if ((diff_reg > prior_reg) && (used_reg != '0))
                begin
                    state_next = S_SAMPLE;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_SAMPLE:
            begin
                if (sample_ok)
                begin
                    req_valid = 1'b1;
                    if (req_ready)
                    begin
                        state_next = S_EXPIRE;
                    end
                end
                else
                begin
                    state_next = S_EXPIRE;
                end
            end
            S_EXPIRE:
            begin
                req.rel_time = front + wl64;
                req.last     = !next_exp;
                if ((used_reg != '0) && head_exp)
                begin
                    req_valid = 1'b1;
                    if (req_ready)
                    begin
                        pop        = 1'b1;
                        used_next  = used_reg - USED_W'(1);
                        total_next = total_dec;
                    end
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if ((used_reg != '0) && (back_time_reg == t_reg))
                begin
                    push_bump  = 1'b1;
                    total_next = total_inc;
                end
                else if (used_reg == USED_W'(DISTINCT_DEPTH))
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    push_new       = 1'b1;
                    used_next      = used_reg + USED_W'(1);
                    total_next     = total_inc;
                    back_time_next = t_reg;
                end
                prior_next = t_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            start_reg       <= START_RESET;
            stop_reg        <= STOP_RESET;
            wl_reg          <= WIN_RESET;
            scale_reg       <= SCALE_RESET;
            have_origin_reg <= 1'b0;
            origin_reg      <= '0;
            prior_reg       <= '0;
            used_reg        <= '0;
            total_reg       <= '0;
            halted_reg      <= 1'b0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            have_origin_reg <= have_origin_next;
            origin_reg      <= origin_next;
            prior_reg       <= prior_next;
            used_reg        <= used_next;
            total_reg       <= total_next;
            halted_reg      <= halted_next;
            overflow_reg    <= overflow_next;
            // config write transaction
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_START_TIME:    start_reg <= cfg.data;
                    CFG_STOP_TIME:     stop_reg  <= cfg.data;
                    CFG_WINDOW_LENGTH: wl_reg    <= cfg.data[WIN_W-1:0];
                    CFG_RATE_SCALE:    scale_reg <= cfg.data[SCALE_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            ev_reg <= events.event_time;
        end
        diff_reg      <= diff_next;
        t_reg         <= t_next;
        back_time_reg <= back_time_next;
    end

    // row of slot cells, oldest timestamp in cell 0
    for (genvar i = 0; i < DISTINCT_DEPTH; i++)
    begin : g_cell
        logic [TIME_W-1:0] up_time;
        logic [CNT_W-1:0]  up_mult;

        if (i == DISTINCT_DEPTH - 1)
        begin : g_top
            assign up_time = '0;
            assign up_mult = '0;
        end
        else
        begin : g_mid
            assign up_time = cell_time[i+1];
            assign up_mult = cell_mult[i+1];
        end

        assign cell_ctrl[i].shift = pop;
        assign cell_ctrl[i].load  = push_new && (used_reg == USED_W'(i));
        assign cell_ctrl[i].bump  = push_bump && (used_reg == USED_W'(i + 1));

        swer_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .up_time   (up_time),
            .up_mult   (up_mult),
            .load_time (t_reg),
            .slot_time (cell_time[i]),
            .slot_mult (cell_mult[i])
        );
    end

    // rate multiply and output register
    swer_rate u_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .origin    (origin_reg),
        .scale     (scale_reg),
        .rates     (rates)
    );

    // checks on the sequencer and the fill count
    `ASSERT_IMPLIES(a_used_bound, clk, rst_n, 1'b1, used_reg <= USED_W'(DISTINCT_DEPTH))
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, (used_reg != '0) && !push_new)
    `ASSERT_NEXT(a_overflow_sticky, clk, rst_n, overflow_reg, overflow_reg)
    `ASSERT_NEXT(a_halted_sticky, clk, rst_n, halted_reg, halted_reg && (used_reg == $past(used_reg)))

endmodule
